>>> sv/static_btree_key_lookup_assert.svh
// Assertion macros for the static B-tree key lookup block.
// Used by the top level; no other dependencies.
`ifndef STATIC_BTREE_KEY_LOOKUP_ASSERT_SVH
`define STATIC_BTREE_KEY_LOOKUP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SBK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SBK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SBK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SBK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/sbk_pkg.sv
// Package for the static B-tree key lookup: sizes, commands, payload structs.
// No dependencies.
`timescale 1ns / 1ps
package sbk_pkg;
    localparam int MAX_NODES      = 256;
    localparam int SLOTS_PER_NODE = 64;
    localparam int MAX_TOKENS     = 5;
    localparam int TOKEN_BITS     = 24;
    localparam int MAX_DEPTH      = 8;
    localparam int NODE_W  = 8;
    localparam int SLOT_W  = 6;
    localparam int CNT_W   = 7;
    localparam int ENTRY_W = NODE_W + SLOT_W;
    localparam int TOK_W   = 3;
    localparam int DEPTH_W = 4;

    localparam logic [1:0] CMD_WR_ENTRY  = 2'd0;
    localparam logic [1:0] CMD_WR_HEADER = 2'd1;
    localparam logic [1:0] CMD_SEARCH    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    typedef struct packed {
        logic [1:0]                  cmd;
        logic [7:0]                  node_index;
        logic [5:0]                  slot_index;
        logic [23:0]                 token_0;
        logic [23:0]                 token_1;
        logic [23:0]                 token_2;
        logic [23:0]                 token_3;
        logic [23:0]                 token_4;
        logic signed [63:0]          payload;
        logic [6:0]                  entry_count;
        logic                        leaf_flag;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic signed [63:0] count;
        logic [5:0]         leaf_slot;
    } t_out_item;

    typedef logic [MAX_TOKENS-1:0][TOKEN_BITS-1:0] t_key;
endpackage

>>> sv/sbk_node_mem.sv
// Entry memory: keys and payloads per node slot, registered read.
// Depends on sbk_pkg.
`timescale 1ns / 1ps
module sbk_node_mem (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [sbk_pkg::ENTRY_W-1:0] i_waddr,
    input  sbk_pkg::t_key             i_wkey,
    input  logic [63:0]               i_wpay,
    input  logic [sbk_pkg::ENTRY_W-1:0] i_raddr,
    output sbk_pkg::t_key             o_rkey,
    output logic [63:0]               o_rpay
);
    localparam int DEPTH = sbk_pkg::MAX_NODES * sbk_pkg::SLOTS_PER_NODE;
    sbk_pkg::t_key r_key_mem [DEPTH];
    logic [63:0]   r_pay_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_key_mem[i_waddr] <= i_wkey;
            r_pay_mem[i_waddr] <= i_wpay;
        end
        o_rkey <= r_key_mem[i_raddr];
        o_rpay <= r_pay_mem[i_raddr];
    end
endmodule

>>> sv/sbk_ctrl.sv
// Search sequencer: binary search per node, descent, headers, result register.
// Depends on sbk_pkg and sbk_node_mem.
`timescale 1ns / 1ps
module sbk_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sbk_pkg::t_in_item i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sbk_pkg::t_out_item o_out,
    input  logic [2:0]        i_key_len
);
    typedef enum logic [2:0] {S_IDLE, S_NODE, S_PROBE, S_CMP, S_LEAF, S_DONE} t_state;
    t_state r_state;
    logic [sbk_pkg::CNT_W-1:0]     r_cnt_mem [sbk_pkg::MAX_NODES];
    logic                          r_leaf_mem [sbk_pkg::MAX_NODES];
    logic [sbk_pkg::MAX_NODES-1:0] r_hdr_vld;
    logic [sbk_pkg::CNT_W-1:0]     r_cnt_rd;
    logic                          r_leaf_rd;
    logic                          r_vld_rd;
    logic                          r_leaf_cur;
    sbk_pkg::t_key r_q;
    logic [2:0] r_len;
    logic [sbk_pkg::NODE_W-1:0]  r_cur;
    logic [sbk_pkg::SLOT_W-1:0]  r_lo, r_hi, r_mid;
    logic [sbk_pkg::DEPTH_W-1:0] r_depth;
    sbk_pkg::t_out_item r_out;

    logic we;
    logic hdr_we;
    logic [sbk_pkg::CNT_W-1:0] hdr_cnt;
    logic [sbk_pkg::NODE_W-1:0] hdr_raddr;
    logic [sbk_pkg::CNT_W-1:0] cur_cnt;
    logic [sbk_pkg::ENTRY_W-1:0] raddr;
    sbk_pkg::t_key rkey;
    logic [63:0] rpay;
    logic below, eq;
    logic [sbk_pkg::SLOT_W:0] midsum;

    assign we = i_in_valid && o_in_ready && i_in.cmd == sbk_pkg::CMD_WR_ENTRY;
    assign hdr_we = i_in_valid && o_in_ready && i_in.cmd == sbk_pkg::CMD_WR_HEADER;
    assign hdr_cnt = (i_in.entry_count > sbk_pkg::CNT_W'(sbk_pkg::SLOTS_PER_NODE)) ?
                     sbk_pkg::CNT_W'(sbk_pkg::SLOTS_PER_NODE) : i_in.entry_count;
    // header read issued at the edge that enters S_NODE
    assign hdr_raddr = (r_state == S_LEAF) ? rpay[sbk_pkg::NODE_W-1:0] : '0;
    assign cur_cnt = r_vld_rd ? r_cnt_rd : '0;
    assign midsum = ({1'b0, r_lo} + {1'b0, r_hi} + 7'd1) >> 1;
    assign raddr = (r_state == S_PROBE) ?
                   {r_cur, (r_lo == r_hi) ? r_lo : midsum[sbk_pkg::SLOT_W-1:0]} :
                   {r_cur, r_mid};

    sbk_node_mem u_mem (
        .i_clk(i_clk), .i_we(we), .i_waddr({i_in.node_index, i_in.slot_index}),
        .i_wkey({i_in.token_4, i_in.token_3, i_in.token_2, i_in.token_1, i_in.token_0}),
        .i_wpay(i_in.payload), .i_raddr(raddr), .o_rkey(rkey), .o_rpay(rpay)
    );

    always_ff @(posedge i_clk) begin
        if (hdr_we) begin
            r_cnt_mem[i_in.node_index]  <= hdr_cnt;
            r_leaf_mem[i_in.node_index] <= i_in.leaf_flag;
        end
        r_cnt_rd  <= r_cnt_mem[hdr_raddr];
        r_leaf_rd <= r_leaf_mem[hdr_raddr];
        r_vld_rd  <= r_hdr_vld[hdr_raddr];
    end

    always_comb begin
        below = 1'b0;
        eq = 1'b1;
        for (int t = sbk_pkg::MAX_TOKENS - 1; t >= 0; t--) begin
            if (t < int'(r_len)) begin
                if (r_q[t] < rkey[t]) begin below = 1'b1; eq = 1'b0; end
                else if (r_q[t] > rkey[t]) begin below = 1'b0; eq = 1'b0; end
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE) && !o_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hdr_vld <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) o_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_out <= '0;
                        if (i_in.cmd == sbk_pkg::CMD_SEARCH) begin
                            r_q <= {i_in.token_4, i_in.token_3, i_in.token_2,
                                    i_in.token_1, i_in.token_0};
                            r_len <= (i_key_len == 3'd0) ? 3'd1 :
                                     (i_key_len > 3'd5) ? 3'd5 : i_key_len;
                            r_cur <= '0;
                            r_depth <= '0;
                            r_state <= S_NODE;
                        end else begin
                            if (i_in.cmd == sbk_pkg::CMD_WR_HEADER) begin
                                r_hdr_vld[i_in.node_index] <= 1'b1;
                            end
                            o_out_valid <= 1'b1;
                        end
                    end
                end
                S_NODE: begin
                    if (cur_cnt == '0) begin
                        r_out.status <= sbk_pkg::ST_EMPTY;
                        r_state <= S_DONE;
                    end else begin
                        r_lo <= '0;
                        r_hi <= sbk_pkg::SLOT_W'(cur_cnt - 7'd1);
                        r_leaf_cur <= r_leaf_rd;
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (r_lo == r_hi) begin
                        r_mid <= r_lo;
                        r_state <= S_LEAF;
                    end else begin
                        r_mid <= midsum[sbk_pkg::SLOT_W-1:0];
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (below) r_hi <= r_mid - 1'b1;
                    else r_lo <= r_mid;
                    r_state <= S_PROBE;
                end
                S_LEAF: begin
                    if (r_leaf_cur) begin
                        r_out.leaf_slot <= r_mid;
                        if (eq) begin
                            r_out.found <= 1'b1;
                            r_out.count <= rpay;
                        end
                        r_state <= S_DONE;
                    end else if (rpay >= 64'(sbk_pkg::MAX_NODES) ||
                                 r_depth == sbk_pkg::DEPTH_W'(sbk_pkg::MAX_DEPTH - 1)) begin
                        r_out.status <= sbk_pkg::ST_BAD;
                        r_state <= S_DONE;
                    end else begin
                        r_cur <= rpay[sbk_pkg::NODE_W-1:0];
                        r_depth <= r_depth + 1'b1;
                        r_state <= S_NODE;
                    end
                end
                S_DONE: begin
                    o_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> sv/static_btree_key_lookup.sv
// Top level of the static B-tree key lookup: config register, sequencer, checks.
// Depends on sbk_pkg, sbk_ctrl and static_btree_key_lookup_assert.svh.
//
// Usage: one input channel (i_in_valid/o_in_ready, payload i_in) carries
// entry writes, node header writes and searches; one output channel
// (o_out_valid/i_out_ready, payload o_out) returns one item per input item.
// A config channel (i_cfg_valid/o_cfg_ready, i_cfg_data) sets key_length.
// Writes answer in the cycle after acceptance. A search walks the tree from
// node 0; at each node it reads the header, then runs a binary search over
// the entries, the probe loop bound by the single read port of the entry
// memory, then descends to the child or stops at a leaf; up to 8 levels,
// with at most 64 entries per node, before the result is posted.
// One item is in flight at a time; a new item is taken once the result has
// been taken. Reset clears all node headers, sets key_length to 5 and
// empties the output; entry memory is not cleared.
// A stalled receiver holds the result and blocks new items.
`timescale 1ns / 1ps
`include "static_btree_key_lookup_assert.svh"
module static_btree_key_lookup (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sbk_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sbk_pkg::t_out_item o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_data
);
    logic [2:0] r_key_len;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_key_len <= 3'd5;
        else if (i_cfg_valid) r_key_len <= i_cfg_data;
    end

    sbk_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_key_len(r_key_len)
    );

    `SBK_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `SBK_ASSERT_IMPL(a_err_clean, i_clk, i_rst_n, o_out_valid && o_out.status != sbk_pkg::ST_OK,
        !o_out.found && o_out.count == 64'd0)
    `SBK_ASSERT_NEXT(a_write_ack, i_clk, i_rst_n,
        i_in_valid && o_in_ready && i_in.cmd != sbk_pkg::CMD_SEARCH, o_out_valid)
endmodule

>>> verif/static_btree_key_lookup_test.sv
// Self-checking testbench for static_btree_key_lookup: loads B-trees, runs searches
// and checks every result against an in-bench predictor. Depends on sbk_pkg.
`timescale 1ns / 1ps
module static_btree_key_lookup_test;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int N_DIRECTED   = 15;

    typedef struct packed {
        sbk_pkg::t_in_item  it;
        logic               has_want;
        sbk_pkg::t_out_item want;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    sbk_pkg::t_in_item  i_in;
    logic               o_out_valid;
    logic               i_out_ready;
    sbk_pkg::t_out_item o_out;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_data;

    static_btree_key_lookup u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // tree shadow
    sbk_pkg::t_key   key_mem [sbk_pkg::MAX_NODES][sbk_pkg::SLOTS_PER_NODE];
    logic [63:0]     pay_mem [sbk_pkg::MAX_NODES][sbk_pkg::SLOTS_PER_NODE];
    logic [6:0]      node_cnt [sbk_pkg::MAX_NODES];
    logic            node_leaf [sbk_pkg::MAX_NODES];
    logic [2:0]      key_len_reg;
    bit              slot_written [sbk_pkg::MAX_NODES][sbk_pkg::SLOTS_PER_NODE];

    sbk_pkg::t_out_item results_due[$];
    sbk_pkg::t_key      stored_keys[$];
    t_row               dir_rows [N_DIRECTED];

    int n_errors, n_items, n_checked, n_search, n_found, n_fault;
    int send_pct, stall_pct, hold_left;
    longint cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT_CYCLES) begin
                $display("timeout after %0d cycles, %0d results pending", cycles,
                         results_due.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic bit query_below(int n, int s, sbk_pkg::t_key q, int len);
        for (int t = 0; t < len; t++) begin
            if (q[t] < key_mem[n][s][t]) return 1'b1;
            if (q[t] > key_mem[n][s][t]) return 1'b0;
        end
        return 1'b0;
    endfunction

    function automatic int pick_slot(int n, sbk_pkg::t_key q, int len);
        int lo, hi, mid;
        lo = 0;
        hi = int'(node_cnt[n]) - 1;
        while (lo != hi) begin
            mid = (lo + hi + 1) / 2;
            if (query_below(n, mid, q, len)) hi = mid - 1;
            else lo = mid;
        end
        return lo;
    endfunction

    function automatic sbk_pkg::t_key item_key(sbk_pkg::t_in_item it);
        sbk_pkg::t_key k;
        k[0] = it.token_0;
        k[1] = it.token_1;
        k[2] = it.token_2;
        k[3] = it.token_3;
        k[4] = it.token_4;
        return k;
    endfunction

    // Applies one item to the shadow tree and returns the lookup answer.
    function automatic sbk_pkg::t_out_item lookup_answer(sbk_pkg::t_in_item it);
        sbk_pkg::t_out_item r;
        sbk_pkg::t_key q;
        int len, cur, s, depth;
        bit done, eq;
        logic [63:0] child;
        r = '0;
        q = item_key(it);
        if (it.cmd == sbk_pkg::CMD_WR_ENTRY) begin
            key_mem[it.node_index][it.slot_index] = q;
            pay_mem[it.node_index][it.slot_index] = it.payload;
        end else if (it.cmd == sbk_pkg::CMD_WR_HEADER) begin
            node_cnt[it.node_index]  = (it.entry_count > sbk_pkg::SLOTS_PER_NODE) ?
                                       7'(sbk_pkg::SLOTS_PER_NODE) : it.entry_count;
            node_leaf[it.node_index] = it.leaf_flag;
        end else if (it.cmd == sbk_pkg::CMD_SEARCH) begin
            len = (key_len_reg == 0) ? 1 :
                  (key_len_reg > sbk_pkg::MAX_TOKENS) ? sbk_pkg::MAX_TOKENS :
                  int'(key_len_reg);
            cur = 0;
            done = 1'b0;
            for (depth = 0; depth < sbk_pkg::MAX_DEPTH && !done; depth++) begin
                if (node_cnt[cur] == 0) begin
                    r.status = sbk_pkg::ST_EMPTY;
                    done = 1'b1;
                    break;
                end
                s = pick_slot(cur, q, len);
                if (node_leaf[cur]) begin
                    eq = 1'b1;
                    for (int t = 0; t < len; t++)
                        if (key_mem[cur][s][t] != q[t]) eq = 1'b0;
                    r.leaf_slot = 6'(s);
                    if (eq) begin
                        r.found = 1'b1;
                        r.count = pay_mem[cur][s];
                    end
                    done = 1'b1;
                end else begin
                    child = pay_mem[cur][s];
                    if (child >= 64'(sbk_pkg::MAX_NODES)) begin
                        r.status = sbk_pkg::ST_BAD;
                        done = 1'b1;
                    end else begin
                        cur = int'(child);
                    end
                end
            end
            if (!done) r.status = sbk_pkg::ST_BAD;
            if (r.status != sbk_pkg::ST_OK) r = '0 | {r.status, 1'b0, 64'd0, 6'd0};
        end
        return r;
    endfunction

    function automatic int filled_prefix(int n);
        int p;
        p = 0;
        while (p < sbk_pkg::SLOTS_PER_NODE && slot_written[n][p]) p++;
        return p;
    endfunction

    function automatic sbk_pkg::t_in_item mk_item(logic [1:0] cmd, int node, int slot,
                                                  sbk_pkg::t_key k, logic [63:0] pay,
                                                  int ec, bit lf);
        sbk_pkg::t_in_item it;
        it.cmd         = cmd;
        it.node_index  = 8'(node);
        it.slot_index  = 6'(slot);
        it.token_0     = k[0];
        it.token_1     = k[1];
        it.token_2     = k[2];
        it.token_3     = k[3];
        it.token_4     = k[4];
        it.payload     = pay;
        it.entry_count = 7'(ec);
        it.leaf_flag   = lf;
        return it;
    endfunction

    function automatic sbk_pkg::t_key rand_key();
        sbk_pkg::t_key k;
        for (int t = 0; t < sbk_pkg::MAX_TOKENS; t++) k[t] = 24'($urandom);
        return k;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        n_errors++;
        $display("[%0t] mismatch %s: got %0h want %0h", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        sbk_pkg::t_out_item w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (results_due.size() == 0) begin
                n_errors++;
                $display("[%0t] result item with nothing pending", $time);
            end else begin
                w = results_due.pop_front();
                n_checked++;
                if (o_out.status !== w.status) report("status", o_out.status, w.status);
                if (o_out.found !== w.found) report("found", o_out.found, w.found);
                if (o_out.count !== w.count) report("count", o_out.count, w.count);
                if (o_out.leaf_slot !== w.leaf_slot)
                    report("leaf_slot", o_out.leaf_slot, w.leaf_slot);
            end
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send(sbk_pkg::t_in_item it, bit has_want = 1'b0,
                        sbk_pkg::t_out_item want = '0);
        sbk_pkg::t_out_item p;
        i_in       <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        p = lookup_answer(it);
        results_due.push_back(has_want ? want : p);
        n_items++;
        if (it.cmd == sbk_pkg::CMD_SEARCH) begin
            n_search++;
            if (p.found) n_found++;
            if (p.status != sbk_pkg::ST_OK) n_fault++;
        end
        if (it.cmd == sbk_pkg::CMD_WR_ENTRY) slot_written[it.node_index][it.slot_index] = 1'b1;
        if (send_pct > 0 && $urandom_range(0, 99) < send_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic set_key_len(logic [2:0] v);
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        key_len_reg = v;
    endtask

    // Two or three level tree: leaves at nodes 2.., index node 0 or 1.
    task automatic build_tree(int n_leaf, int per_leaf, bit three_level);
        int idx_node, ec;
        sbk_pkg::t_key k, first [$];
        logic [23:0] start;
        stored_keys.delete();
        start = 24'($urandom_range(0, 24'hFFFFFF - 700_000));
        for (int j = 0; j < n_leaf; j++) begin
            for (int i = 0; i < per_leaf; i++) begin
                k = rand_key();
                k[0] = start + 24'((j * 64 + i) * 1000 + $urandom_range(0, 499));
                if (i == 0) first.push_back(k);
                stored_keys.push_back(k);
                send(mk_item(sbk_pkg::CMD_WR_ENTRY, 2 + j, i, k, {$urandom, $urandom},
                             0, 1'b0));
            end
            ec = (per_leaf == sbk_pkg::SLOTS_PER_NODE) ? $urandom_range(64, 127) : per_leaf;
            send(mk_item(sbk_pkg::CMD_WR_HEADER, 2 + j, 0, rand_key(), {$urandom, $urandom},
                         ec, 1'b1));
        end
        idx_node = three_level ? 1 : 0;
        for (int j = 0; j < n_leaf; j++)
            send(mk_item(sbk_pkg::CMD_WR_ENTRY, idx_node, j, first[j], 64'(2 + j), 0, 1'b0));
        send(mk_item(sbk_pkg::CMD_WR_HEADER, idx_node, 0, rand_key(), 64'd0, n_leaf, 1'b0));
        if (three_level) begin
            send(mk_item(sbk_pkg::CMD_WR_ENTRY, 0, 0, '0, 64'd1, 0, 1'b0));
            send(mk_item(sbk_pkg::CMD_WR_HEADER, 0, 0, rand_key(), 64'd0, 1, 1'b0));
        end
    endtask

    task automatic random_item();
        int roll, n, pf;
        sbk_pkg::t_key k;
        roll = $urandom_range(0, 99);
        if (roll < 45 && stored_keys.size() > 0) begin
            k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            send(mk_item(sbk_pkg::CMD_SEARCH, $urandom, $urandom, k, {$urandom, $urandom},
                         $urandom, 1'($urandom)));
        end else if (roll < 62 && stored_keys.size() > 0) begin
            k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            n = $urandom_range(0, sbk_pkg::MAX_TOKENS - 1);
            k[n] = ($urandom_range(0, 1)) ? k[n] + 24'd1 : k[n] - 24'd1;
            send(mk_item(sbk_pkg::CMD_SEARCH, $urandom, $urandom, k, {$urandom, $urandom},
                         $urandom, 1'($urandom)));
        end else if (roll < 75) begin
            send(mk_item(sbk_pkg::CMD_SEARCH, $urandom, $urandom, rand_key(),
                         {$urandom, $urandom}, $urandom, 1'($urandom)));
        end else if (roll < 85) begin
            send(mk_item(sbk_pkg::CMD_WR_ENTRY, $urandom_range(0, 255), $urandom_range(0, 63),
                         rand_key(), {$urandom, $urandom}, $urandom, 1'($urandom)));
        end else if (roll < 95) begin
            n  = $urandom_range(0, 255);
            pf = filled_prefix(n);
            send(mk_item(sbk_pkg::CMD_WR_HEADER, n, $urandom, rand_key(), {$urandom, $urandom},
                         (pf == sbk_pkg::SLOTS_PER_NODE && $urandom_range(0, 1)) ?
                         $urandom_range(64, 127) : $urandom_range(0, pf), 1'($urandom)));
        end else begin
            send(mk_item(2'd3, $urandom, $urandom, rand_key(), {$urandom, $urandom},
                         $urandom, 1'($urandom)));
        end
    endtask

    initial begin
        sbk_pkg::t_key kmax;
        sbk_pkg::t_out_item ack;
        logic [2:0] len_plan [8];
        len_plan = '{3'd5, 3'd1, 3'd3, 3'd0, 3'd7, 3'd2, 3'd6, 3'd4};
        n_errors = 0; n_items = 0; n_checked = 0; n_search = 0; n_found = 0; n_fault = 0;
        send_pct = 0; stall_pct = 0; hold_left = 0;
        key_len_reg = 3'd5;
        for (int n = 0; n < sbk_pkg::MAX_NODES; n++) begin
            node_cnt[n] = '0;
            node_leaf[n] = 1'b0;
            for (int s = 0; s < sbk_pkg::SLOTS_PER_NODE; s++) slot_written[n][s] = 1'b0;
        end
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;

        kmax = {sbk_pkg::MAX_TOKENS{24'hFFFFFF}};
        ack  = '0;
        dir_rows[0]  = '{mk_item(sbk_pkg::CMD_SEARCH, 0, 0, '0, 64'd0, 0, 1'b0), 1'b1,
                         sbk_pkg::t_out_item'{sbk_pkg::ST_EMPTY, 1'b0, 64'sd0, 6'd0}};
        dir_rows[1]  = '{mk_item(2'd3, 255, 63, kmax, '1, 127, 1'b1), 1'b1, ack};
        dir_rows[2]  = '{mk_item(sbk_pkg::CMD_WR_ENTRY, 0, 0, kmax, 64'd0, 0, 1'b0), 1'b1, ack};
        dir_rows[3]  = '{mk_item(sbk_pkg::CMD_WR_HEADER, 0, 0, '0, 64'd0, 1, 1'b0), 1'b1, ack};
        // root points at itself: too deep
        dir_rows[4]  = '{mk_item(sbk_pkg::CMD_SEARCH, 0, 0, kmax, 64'd0, 0, 1'b0), 1'b1,
                         sbk_pkg::t_out_item'{sbk_pkg::ST_BAD, 1'b0, 64'sd0, 6'd0}};
        dir_rows[5]  = '{mk_item(sbk_pkg::CMD_WR_ENTRY, 0, 0, kmax, '1, 0, 1'b0), 1'b1, ack};
        dir_rows[6]  = '{mk_item(sbk_pkg::CMD_SEARCH, 0, 0, kmax, 64'd0, 0, 1'b0), 1'b1,
                         sbk_pkg::t_out_item'{sbk_pkg::ST_BAD, 1'b0, 64'sd0, 6'd0}};
        dir_rows[7]  = '{mk_item(sbk_pkg::CMD_WR_ENTRY, 0, 0, kmax, 64'd256, 0, 1'b0),
                         1'b1, ack};
        dir_rows[8]  = '{mk_item(sbk_pkg::CMD_SEARCH, 0, 0, '0, 64'd0, 0, 1'b0), 1'b1,
                         sbk_pkg::t_out_item'{sbk_pkg::ST_BAD, 1'b0, 64'sd0, 6'd0}};
        dir_rows[9]  = '{mk_item(sbk_pkg::CMD_WR_ENTRY, 0, 0, kmax, 64'h8000_0000_0000_0000,
                                 0, 1'b0), 1'b1, ack};
        dir_rows[10] = '{mk_item(sbk_pkg::CMD_WR_HEADER, 0, 0, '0, 64'd0, 1, 1'b1), 1'b1, ack};
        dir_rows[11] = '{mk_item(sbk_pkg::CMD_SEARCH, 0, 0, kmax, 64'd0, 0, 1'b0), 1'b1,
                         sbk_pkg::t_out_item'{sbk_pkg::ST_OK, 1'b1,
                                              64'sh8000_0000_0000_0000, 6'd0}};
        dir_rows[12] = '{mk_item(sbk_pkg::CMD_SEARCH, 0, 0, '0, 64'd0, 0, 1'b0), 1'b1,
                         sbk_pkg::t_out_item'{sbk_pkg::ST_OK, 1'b0, 64'sd0, 6'd0}};
        dir_rows[13] = '{mk_item(sbk_pkg::CMD_WR_ENTRY, 255, 63, '0, 64'h7FFF_FFFF_FFFF_FFFF,
                                 0, 1'b0), 1'b1, ack};
        dir_rows[14] = '{mk_item(sbk_pkg::CMD_WR_HEADER, 255, 0, '0, 64'd0, 0, 1'b1),
                         1'b0, ack};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++)
            send(dir_rows[r].it, dir_rows[r].has_want, dir_rows[r].want);

        for (int ph = 0; ph < 8; ph++) begin
            set_key_len(len_plan[ph]);
            send_pct  = (ph % 4 == 1) ? 47 : (ph % 4 == 3) ? 11 : 0;
            stall_pct = (ph % 4 == 2) ? 47 : (ph % 4 == 3) ? 11 : 0;
            if (ph == 1) hold_left = 400;
            if (ph == 4) build_tree(1, sbk_pkg::SLOTS_PER_NODE, 1'b1);
            else build_tree($urandom_range(1, 6), $urandom_range(1, 12),
                            1'($urandom_range(0, 1)));
            repeat (95) random_item();
        end
        i_in_valid <= 1'b0;

        while (results_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("%0d items sent, %0d results checked: %0d searches, %0d hits, %0d faults",
                 n_items, n_checked, n_search, n_found, n_fault);
        $display("key lengths 0..7 visited across idle and stall phases, mismatches %0d",
                 n_errors);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

>>> static_btree_key_lookup.f
+incdir+sv
sv/sbk_pkg.sv
sv/sbk_node_mem.sv
sv/sbk_ctrl.sv
sv/static_btree_key_lookup.sv
verif/static_btree_key_lookup_test.sv
